>>> sv/ffgra_pkg.sv
// ----------------------------------------------------------------------------
// ffgra_pkg
// Shared types and constants of the first-fit grid rectangle allocator:
// request and result codes, register indexes and controller command bundles.
// ----------------------------------------------------------------------------
package ffgra_pkg;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  // field widths of the request and result
  localparam int SIZE_W = 5;
  localparam int POS_W  = 4;
  localparam int CFG_W  = 5;
  localparam int CFG_AW = 1;

  // width of row and column sums: holds 64 + 31 with room to spare
  localparam int SUM_W = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    ACT_CLEAR = 1'b0,
    ACT_PLACE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEARED = 2'd0,
    ST_PLACED  = 2'd1,
    ST_NOROOM  = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

  // which result the datapath records
  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_CLEARED = 3'd1,
    RES_ZERO    = 3'd2,
    RES_NOROOM  = 3'd3,
    RES_PLACED  = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     clear_grid;
    logic     init_scan;
    logic     rd_issue;
    logic     next_row;
    logic     set_found;
    logic     mark_rd;
    logic     mark_wr;
    logic     load_out;
    res_sel_t res_set;
  } cmd_t;

  typedef struct packed {
    logic place;
    logic need_zero;
    logic grid_ok;
    logic oversize;
    logic k_last;
    logic last_row;
    logic fit_any;
  } sts_t;

endpackage

>>> sv/ffgra_ctrl.sv
// ----------------------------------------------------------------------------
// ffgra_ctrl
// Sequencer of the allocator: takes a request, steps the datapath through the
// row-by-row search and the marking pass, and hands the result to the output.
// ----------------------------------------------------------------------------
module ffgra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ffgra_pkg::sts_t   sts,
  output ffgra_pkg::cmd_t   cmd
);
  import ffgra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WAIT,
    S_EVAL,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_set   = RES_NONE;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.place) begin
          cmd.clear_grid = 1'b1;
          cmd.res_set    = RES_CLEARED;
          state_nxt      = S_DONE;
        end else if (sts.need_zero) begin
          cmd.res_set = sts.grid_ok ? RES_ZERO : RES_NOROOM;
          state_nxt   = S_DONE;
        end else if (sts.oversize) begin
          cmd.res_set = RES_NOROOM;
          state_nxt   = S_DONE;
        end else begin
          cmd.init_scan = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_WAIT;
        end
      end
      // last row read of this start row lands in the accumulator
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.fit_any) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_MARK_RD;
        end else if (sts.last_row) begin
          cmd.res_set = RES_NOROOM;
          state_nxt   = S_DONE;
        end else begin
          cmd.next_row = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_nxt   = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        if (sts.k_last) begin
          cmd.res_set = RES_PLACED;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_MARK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/ffgra_dp.sv
// ----------------------------------------------------------------------------
// ffgra_dp
// Datapath of the allocator: grid size registers, occupancy memory with row
// valid bits, row accumulator, column fit search and result registers.
// ----------------------------------------------------------------------------
module ffgra_dp #(
  parameter int MAX_ROWS = ffgra_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ffgra_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ffgra_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ffgra_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_action,
  input  logic [ffgra_pkg::SIZE_W-1:0]  in_item_rows,
  input  logic [ffgra_pkg::SIZE_W-1:0]  in_item_cols,
  input  ffgra_pkg::cmd_t               cmd,
  output ffgra_pkg::sts_t               sts,
  output ffgra_pkg::status_t            out_status,
  output logic [ffgra_pkg::POS_W-1:0]   out_at_row,
  output logic [ffgra_pkg::POS_W-1:0]   out_at_col
);
  import ffgra_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CFG_W-1:0]    grid_rows_r, grid_cols_r;
  logic                action_r;
  logic [SIZE_W-1:0]   need_r_r, need_c_r;
  logic [SUM_W-1:0]    row_r, k_r;
  logic [MAX_COLS-1:0] acc_r;
  logic                scan_vld_r;
  logic [MAX_COLS-1:0] mem [0:MAX_ROWS-1];
  logic [MAX_ROWS-1:0] row_valid_r;
  logic [MAX_COLS-1:0] mem_q_r;
  logic                mem_qv_r;
  logic [CW-1:0]       col_r;
  logic [MAX_COLS-1:0] mask_r;
  status_t             res_status_r, out_status_r;
  logic [POS_W-1:0]    res_row_r, res_col_r, out_row_r, out_col_r;

  logic [SUM_W-1:0]    rows_eff, cols_eff, need_rx, need_cx, addr_sum;
  logic [AW-1:0]       addr;
  logic [MAX_COLS-1:0] old_row, span;
  logic                rd_en;
  logic                fit_any;
  logic [CW-1:0]       fit_col;

  // sizes above the built grid saturate
  assign rows_eff = (SUM_W'(grid_rows_r) > SUM_W'(MAX_ROWS)) ? SUM_W'(MAX_ROWS)
                                                             : SUM_W'(grid_rows_r);
  assign cols_eff = (SUM_W'(grid_cols_r) > SUM_W'(MAX_COLS)) ? SUM_W'(MAX_COLS)
                                                             : SUM_W'(grid_cols_r);
  assign need_rx  = SUM_W'(need_r_r);
  assign need_cx  = SUM_W'(need_c_r);
  assign addr_sum = row_r + k_r;
  assign addr     = addr_sum[AW-1:0];
  assign rd_en    = cmd.rd_issue | cmd.mark_rd;
  // a row never written since the last clear reads as free
  assign old_row  = mem_qv_r ? mem_q_r : '0;
  // shift by the full width or more leaves zero, so span saturates to all ones
  assign span     = ~({MAX_COLS{1'b1}} << need_c_r);

  // lowest start column whose window is free and inside the grid
  always_comb begin
    fit_any = 1'b0;
    fit_col = '0;
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if ((SUM_W'(c) + need_cx <= cols_eff) && ((acc_r & (span << c)) == '0)) begin
        fit_any = 1'b1;
        fit_col = CW'(c);
      end
    end
  end

  always_comb begin
    sts.place     = (action_r == ACT_PLACE);
    sts.need_zero = (need_r_r == '0) || (need_c_r == '0);
    sts.grid_ok   = (rows_eff != '0) && (cols_eff != '0);
    sts.oversize  = (need_rx > rows_eff) || (need_cx > cols_eff);
    sts.k_last    = (k_r == need_rx - SUM_W'(1));
    sts.last_row  = (row_r + SUM_W'(1) + need_rx > rows_eff);
    sts.fit_any   = fit_any;
  end

  // grid size registers and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_W'(16);
      grid_cols_r <= CFG_W'(16);
      row_valid_r <= '0;
      scan_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
          REG_GRID_COLS: grid_cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear_grid) begin
        row_valid_r <= '0;
      end else if (cmd.mark_wr) begin
        row_valid_r[addr] <= 1'b1;
      end
      scan_vld_r <= cmd.rd_issue;
    end
  end

  // occupancy memory, one word per row
  always_ff @(posedge clk) begin
    if (cmd.mark_wr) begin
      mem[addr] <= old_row | mask_r;
    end
    if (rd_en) begin
      mem_q_r  <= mem[addr];
      mem_qv_r <= row_valid_r[addr];
    end
  end

  // request, search and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_r <= in_action;
      need_r_r <= in_item_rows;
      need_c_r <= in_item_cols;
    end
    if (cmd.init_scan) begin
      row_r <= '0;
    end else if (cmd.next_row) begin
      row_r <= row_r + SUM_W'(1);
    end
    if (cmd.init_scan || cmd.next_row || cmd.set_found) begin
      k_r <= '0;
    end else if (cmd.rd_issue || cmd.mark_wr) begin
      k_r <= k_r + SUM_W'(1);
    end
    if (cmd.init_scan || cmd.next_row) begin
      acc_r <= '0;
    end else if (scan_vld_r) begin
      acc_r <= acc_r | old_row;
    end
    if (cmd.set_found) begin
      col_r  <= fit_col;
      mask_r <= span << fit_col;
    end
    case (cmd.res_set)
      RES_CLEARED: begin
        res_status_r <= ST_CLEARED;
        res_row_r    <= '0;
        res_col_r    <= '0;
      end
      RES_ZERO: begin
        res_status_r <= ST_PLACED;
        res_row_r    <= '0;
        res_col_r    <= '0;
      end
      RES_NOROOM: begin
        res_status_r <= ST_NOROOM;
        res_row_r    <= '0;
        res_col_r    <= '0;
      end
      RES_PLACED: begin
        res_status_r <= ST_PLACED;
        res_row_r    <= POS_W'(row_r);
        res_col_r    <= POS_W'(col_r);
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_row_r    <= res_row_r;
      out_col_r    <= res_col_r;
    end
  end

  assign out_status = out_status_r;
  assign out_at_row = out_row_r;
  assign out_at_col = out_col_r;

endmodule

>>> sv/first_fit_grid_rectangle_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_grid_rectangle_allocator_core
// First-fit placement of rectangles on an occupancy grid of up to
// MAX_ROWS by MAX_COLS cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one request per beat: in_tuser is the action (clear or
//   place), in_tdata the rectangle height and width. out_* returns one
//   result beat per request: out_tuser status, out_tdata top row and left col.
//   cfg_we/cfg_addr/cfg_wdata write grid_rows (index 0) or grid_cols
//   (index 1); write only while no request is in flight.
// Request sequence:
//   a clear clears the grid in the check state, then loads its result. A
//   place request passes the check state, then for each start row tried
//   one occupancy memory read per covered row and the column fit search,
//   then a read and a write of each covered row to mark it, then the
//   output load; the single read port of the occupancy memory orders this.
//   One request is in flight at a time; in_tready is high while idle.
// Reset and stall:
//   reset frees every cell at once through the row valid bits and sets both
//   grid sizes to 16. A result held by a stalled receiver waits in the
//   output register; the next request is accepted and searched meanwhile
//   and its result waits until the earlier one is taken.
// ----------------------------------------------------------------------------
module first_fit_grid_rectangle_allocator_core #(
  parameter int MAX_ROWS = ffgra_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ffgra_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ffgra_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [ffgra_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffgra_pkg::IN_TDATA_W-1:0]    in_tdata,   // item_rows, item_cols, zero pad
  input  logic                                in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ffgra_pkg::OUT_TDATA_W-1:0]   out_tdata,  // at_row, at_col
  output logic [1:0]                          out_tuser   // status
);
  import ffgra_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  status_t          status;
  logic [POS_W-1:0] at_row, at_col;

  ffgra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ffgra_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_action    (in_tuser),
    .in_item_rows (in_tdata[SIZE_W-1:0]),
    .in_item_cols (in_tdata[2*SIZE_W-1:SIZE_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (status),
    .out_at_row   (at_row),
    .out_at_col   (at_col)
  );

  assign out_tdata = {at_col, at_row};
  assign out_tuser = status;

endmodule

>>> test/ffgra_alloc_checker.sv
// ----------------------------------------------------------------------------
// ffgra_alloc_checker
// Watches the config port and both streams of the rectangle allocator. Keeps
// its own copy of the grid sizes and the occupancy bitmap and predicts every
// result beat. Each result is then compared field by field in arrival order.
// ----------------------------------------------------------------------------
module ffgra_alloc_checker #(
  parameter int MAX_ROWS = ffgra_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ffgra_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ffgra_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [ffgra_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [ffgra_pkg::IN_TDATA_W-1:0]  in_tdata,   // item_rows, item_cols, zero pad
  input  logic                              in_tuser,   // action
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ffgra_pkg::OUT_TDATA_W-1:0] out_tdata,  // at_row, at_col
  input  logic [1:0]                        out_tuser,  // status
  output int                                errors,
  output int                                pending,
  output int                                placed_seen,
  output int                                noroom_seen
);
  import ffgra_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } alloc_t;

  logic [MAX_COLS-1:0] occ [MAX_ROWS];
  logic [CFG_W-1:0]    grid_rows;
  logic [CFG_W-1:0]    grid_cols;
  alloc_t              expected_alloc_q [$];
  int                  mismatch_cnt = 0;
  int                  placed_cnt   = 0;
  int                  noroom_cnt   = 0;

  assign errors      = mismatch_cnt;
  assign placed_seen = placed_cnt;
  assign noroom_seen = noroom_cnt;

  // first-fit search in row-major order; updates the bitmap on a hit
  function automatic alloc_t predict_alloc(input action_t act, input int need_r,
                                           input int need_c);
    alloc_t      res;
    int          rows;
    int          cols;
    logic [63:0] span;
    bit          fits;
    res.status = ST_CLEARED;
    res.row    = '0;
    res.col    = '0;
    rows = (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
    cols = (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
    if (act == ACT_CLEAR) begin
      for (int r = 0; r < MAX_ROWS; r++) occ[r] = '0;
      return res;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        // a zero height or width takes the very first position, marks nothing
        if (need_r != 0 && need_c != 0) begin
          if (r + need_r > rows || c + need_c > cols) continue;
          span = ((64'd1 << need_c) - 64'd1) << c;
          fits = 1'b1;
          for (int k = 0; k < need_r; k++) begin
            if ((occ[r + k] & span[MAX_COLS-1:0]) != '0) fits = 1'b0;
          end
          if (!fits) continue;
          for (int k = 0; k < need_r; k++) occ[r + k] |= span[MAX_COLS-1:0];
        end
        res.status = ST_PLACED;
        res.row    = r[POS_W-1:0];
        res.col    = c[POS_W-1:0];
        return res;
      end
    end
    res.status = ST_NOROOM;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    alloc_t exp_res;
    alloc_t got_res;
    if (!rst_n) begin
      grid_rows = CFG_W'(16);
      grid_cols = CFG_W'(16);
      for (int r = 0; r < MAX_ROWS; r++) occ[r] = '0;
      expected_alloc_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_GRID_ROWS: grid_rows = cfg_wdata;
          REG_GRID_COLS: grid_cols = cfg_wdata;
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got_res.status = status_t'(out_tuser);
        got_res.row    = out_tdata[POS_W-1:0];
        got_res.col    = out_tdata[2*POS_W-1:POS_W];
        if (got_res.status == ST_PLACED) placed_cnt++;
        if (got_res.status == ST_NOROOM) noroom_cnt++;
        if (expected_alloc_q.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d row %0d col %0d",
                   $time, out_tuser, got_res.row, got_res.col);
          mismatch_cnt++;
        end else begin
          exp_res = expected_alloc_q.pop_front();
          if (got_res.status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, out_tuser);
            mismatch_cnt++;
          end
          if (got_res.row !== exp_res.row) begin
            $display("%0t: at_row mismatch: expected %0d, actual %0d",
                     $time, exp_res.row, got_res.row);
            mismatch_cnt++;
          end
          if (got_res.col !== exp_res.col) begin
            $display("%0t: at_col mismatch: expected %0d, actual %0d",
                     $time, exp_res.col, got_res.col);
            mismatch_cnt++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        expected_alloc_q.push_back(predict_alloc(action_t'(in_tuser),
                                                 int'(in_tdata[SIZE_W-1:0]),
                                                 int'(in_tdata[2*SIZE_W-1:SIZE_W])));
      end

      pending <= expected_alloc_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the first-fit grid rectangle allocator: directed corner
// requests, then random phases of place and clear requests over many grid
// sizes, with bursty input and a stalling receiver. A checker predicts and
// compares every result beat; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ffgra_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  int errors;
  int pending;
  int placed_seen;
  int noroom_seen;
  int items_sent    = 0;
  int clears_sent   = 0;
  int grid_settings = 0;
  int burst_left    = 1;

  always #5 clk = ~clk;

  first_fit_grid_rectangle_allocator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ffgra_alloc_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .errors      (errors),
    .pending     (pending),
    .placed_seen (placed_seen),
    .noroom_seen (noroom_seen)
  );

  initial begin : watchdog
    #50_000_000;
    $display("** first_fit_grid_rectangle_allocator_core: FAILED **");
    $finish;
  end

  // receiver: each stretch picks its own ready pattern
  initial begin : rx_pattern
    rx_mode_t mode;
    int       span_len;
    out_tready = 1'b0;
    forever begin
      mode     = rx_mode_t'($urandom_range(0, 3));
      span_len = $urandom_range(32, 200);
      repeat (span_len) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_tready <= ($urandom_range(0, 15) != 0);
          default:   out_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 0;
    if (roll < 9) return $urandom_range(17, 31);
    if (roll < 70) return $urandom_range(1, 4);
    return $urandom_range(1, 16);
  endfunction

  function automatic int pick_grid();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(17, 31);
    if (roll == 2) return 16;
    if (roll == 3) return 1;
    return $urandom_range(1, 16);
  endfunction

  // one request beat; the burst bookkeeping drops valid for a gap now and then
  task automatic send_req(input action_t act, input int need_r, input int need_c);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W - 2*SIZE_W){1'b0}}, need_c[SIZE_W-1:0], need_r[SIZE_W-1:0]};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == ACT_CLEAR) clears_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // resize only with the block idle; the bitmap is left as it is
  task automatic set_grid(input int rows, input int cols);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_GRID_ROWS;
    cfg_wdata <= rows[CFG_W-1:0];
    @(posedge clk);
    cfg_addr  <= REG_GRID_COLS;
    cfg_wdata <= cols[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_settings++;
  endtask

  initial begin : stimulus
    int n;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_GRID_ROWS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_CLEAR;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full grid after reset, zero sizes on a full bitmap, then a clear and oversize
    send_req(ACT_PLACE, 16, 16);
    send_req(ACT_PLACE, 1, 1);
    send_req(ACT_PLACE, 0, 7);
    send_req(ACT_PLACE, 9, 0);
    send_req(ACT_PLACE, 0, 0);
    send_req(ACT_CLEAR, 31, 31);
    send_req(ACT_PLACE, 17, 1);
    send_req(ACT_PLACE, 1, 17);
    send_req(ACT_PLACE, 31, 31);
    send_req(ACT_PLACE, 1, 16);
    send_req(ACT_PLACE, 16, 1);
    send_req(ACT_PLACE, 15, 15);
    send_req(ACT_PLACE, 1, 1);
    // empty grid: nothing fits, not even a zero-sized rectangle
    set_grid(0, 16);
    send_req(ACT_PLACE, 1, 1);
    send_req(ACT_PLACE, 0, 0);
    // sizes above the maximum saturate
    set_grid(31, 31);
    send_req(ACT_PLACE, 4, 4);
    // bits set in a shrunk area still count once it grows back
    set_grid(2, 2);
    send_req(ACT_CLEAR, 0, 0);
    send_req(ACT_PLACE, 2, 2);
    send_req(ACT_PLACE, 1, 1);
    set_grid(4, 4);
    send_req(ACT_PLACE, 2, 2);
    set_grid(1, 16);
    send_req(ACT_PLACE, 1, 16);
    set_grid(16, 1);
    send_req(ACT_PLACE, 16, 1);
    send_req(ACT_PLACE, 1, 1);

    while (items_sent < 1750) begin
      set_grid(pick_grid(), pick_grid());
      if ($urandom_range(0, 2) != 0)
        send_req(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
      n = $urandom_range(8, 40);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        if ($urandom_range(0, 19) == 0)
          send_req(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
        else
          send_req(ACT_PLACE, pick_size(), pick_size());
      end
    end

    drain_results();
    repeat (400) @(posedge clk);

    $display("covered %0d requests (%0d clears) over %0d grid settings",
             items_sent, clears_sent, grid_settings);
    $display("results seen: %0d placed, %0d no room", placed_seen, noroom_seen);
    if (errors == 0 && pending == 0) begin
      $display("** first_fit_grid_rectangle_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_grid_rectangle_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ffgra_pkg.sv
sv/ffgra_ctrl.sv
sv/ffgra_dp.sv
sv/first_fit_grid_rectangle_allocator_core.sv
test/ffgra_alloc_checker.sv
test/tb_top.sv
